FILE: hdl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg: shared definitions of the cursor heading core
// Register indexes, fixed widths, reset values and the arctangent table.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int DEF_ANGLE_FRAC_BITS = 8;
  localparam int DEF_COORD_WIDTH     = 12;

  localparam int OFFSET_WIDTH  = 11;
  localparam int HEADING_WIDTH = 18;
  localparam int REG_IDX_WIDTH = 2;

  localparam int CENTER_X_RESET = 320;
  localparam int CENTER_Y_RESET = 205;

  localparam int CORDIC_STEPS = 24;
  localparam int ZSCALE_BITS  = 24;
  localparam int GUARD_BITS   = 24;
  localparam int ZW           = 34;

  localparam logic signed [ZW-1:0] Z_DEG_90  = 34'sd1509949440;
  localparam logic signed [ZW-1:0] Z_DEG_180 = 34'sd3019898880;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_CENTER_X    = 2'd0,
    REG_CENTER_Y    = 2'd1,
    REG_VERT_OFFSET = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic zero_vec;
    logic add_angle;
  } chd_class_t;

endpackage

FILE: hdl/chd_fifo.sv
// ----------------------------------------------------------------------------
// chd_fifo: two-entry queue
// Small register queue used between the front and back and at the output.
// ----------------------------------------------------------------------------
module chd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("transfer into full queue");
`endif

endmodule

FILE: hdl/chd_front.sv
// ----------------------------------------------------------------------------
// chd_front: configuration and operand front end
// Holds the origin registers, forms the quarter-pixel vector and classifies it.
// ----------------------------------------------------------------------------
module chd_front
  import chd_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [REG_IDX_WIDTH-1:0]            cfg_idx_i,
  input  logic [((COORD_WIDTH > OFFSET_WIDTH) ? COORD_WIDTH : OFFSET_WIDTH)-1:0]
                                              cfg_wdata_i,
  input  logic signed [COORD_WIDTH-1:0]       cursor_x_i,
  input  logic signed [COORD_WIDTH-1:0]       cursor_y_i,
  output logic signed [COORD_WIDTH+3:0]       dx_o,
  output logic signed [COORD_WIDTH+3:0]       dy_o,
  output chd_class_t                          class_o
);

  localparam int DW = COORD_WIDTH + 4;

  logic signed [COORD_WIDTH-1:0]  center_x_q;
  logic signed [COORD_WIDTH-1:0]  center_y_q;
  logic signed [OFFSET_WIDTH-1:0] offset_q;
  logic signed [DW-1:0]           diff_x, diff_y, off_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= COORD_WIDTH'(CENTER_X_RESET);
      center_y_q <= COORD_WIDTH'(CENTER_Y_RESET);
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:    center_x_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CENTER_Y:    center_y_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_VERT_OFFSET: offset_q   <= cfg_wdata_i[OFFSET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff_x  = DW'(cursor_x_i) - DW'(center_x_q);
    diff_y  = DW'(cursor_y_i) - DW'(center_y_q);
    off_ext = DW'(offset_q);
    dx_o    = diff_x <<< 2;
    dy_o    = (diff_y <<< 2) + (off_ext <<< 1) + off_ext;
    class_o.zero_vec  = (dx_o == '0) && (dy_o == '0);
    class_o.add_angle = (dx_o > 0) && (dy_o != '0);
  end

endmodule

FILE: hdl/chd_back.sv
// ----------------------------------------------------------------------------
// chd_back: pipelined vectoring back end
// Pre-rotation, one micro-rotation per stage, then clamp, rounding and heading.
// ----------------------------------------------------------------------------
module chd_back
  import chd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic signed [COORD_WIDTH+3:0]   dx_i,
  input  logic signed [COORD_WIDTH+3:0]   dy_i,
  input  chd_class_t                      class_i,
  output logic                            in_pop_o,
  input  logic                            out_full_i,
  output logic                            out_push_o,
  output logic [HEADING_WIDTH-1:0]        heading_o,
  output logic                            valid_res_o
);

  localparam int DW  = COORD_WIDTH + 4;
  localparam int VW  = COORD_WIDTH + 31;
  localparam int RSH = ZSCALE_BITS - ANGLE_FRAC_BITS;

  logic                 en;
  logic [CORDIC_STEPS:0] vld_q, vld_d;
  logic signed [VW-1:0] vx_q [CORDIC_STEPS+1];
  logic signed [VW-1:0] vx_d [CORDIC_STEPS+1];
  logic signed [VW-1:0] vy_q [CORDIC_STEPS+1];
  logic signed [VW-1:0] vy_d [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q  [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_d  [CORDIC_STEPS+1];
  chd_class_t           cls_q [CORDIC_STEPS+1];
  chd_class_t           cls_d [CORDIC_STEPS+1];

  logic signed [DW-1:0] abs_dx;
  logic [ZW-1:0]        z_clamp, z_rnd, ang, base, head_full;
  logic signed [ZW-1:0] z_last;

  assign en       = !out_full_i;
  assign in_pop_o = en && in_valid_i;

  // pre-rotation into the right half plane
  always_comb begin
    abs_dx   = dx_i[DW-1] ? -dx_i : dx_i;
    vld_d[0] = in_valid_i;
    cls_d[0] = class_i;
    if (dy_i[DW-1]) begin
      vx_d[0] = VW'(abs_dx) <<< GUARD_BITS;
      vy_d[0] = VW'(-dy_i) <<< GUARD_BITS;
      z_d[0]  = Z_DEG_90;
    end else begin
      vx_d[0] = VW'(dy_i) <<< GUARD_BITS;
      vy_d[0] = VW'(abs_dx) <<< GUARD_BITS;
      z_d[0]  = '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [VW-1:0] xs, ys;
    logic signed [ZW-1:0] t_ang;
    always_comb begin
      xs         = vx_q[k] >>> k;
      ys         = vy_q[k] >>> k;
      t_ang      = $signed(ZW'(ATAN_TAB[k]));
      vld_d[k+1] = vld_q[k];
      cls_d[k+1] = cls_q[k];
      if (!vy_q[k][VW-1]) begin
        vx_d[k+1] = vx_q[k] + ys;
        vy_d[k+1] = vy_q[k] - xs;
        z_d[k+1]  = z_q[k] + t_ang;
      end else begin
        vx_d[k+1] = vx_q[k] - ys;
        vy_d[k+1] = vy_q[k] + xs;
        z_d[k+1]  = z_q[k] - t_ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  for (genvar s = 0; s <= CORDIC_STEPS; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        vx_q[s]  <= vx_d[s];
        vy_q[s]  <= vy_d[s];
        z_q[s]   <= z_d[s];
        cls_q[s] <= cls_d[s];
      end
    end
  end

  // clamp, round half up, fold into heading
  always_comb begin
    z_last = z_q[CORDIC_STEPS];
    if (z_last[ZW-1]) begin
      z_clamp = '0;
    end else if (z_last > Z_DEG_180) begin
      z_clamp = Z_DEG_180;
    end else begin
      z_clamp = z_last;
    end
    z_rnd = z_clamp + (ZW'(1) << (RSH - 1));
    ang   = z_rnd >> RSH;
    base  = ZW'(90) << ANGLE_FRAC_BITS;
    if (cls_q[CORDIC_STEPS].add_angle) begin
      head_full = base + ang;
    end else begin
      head_full = base - ang;
    end
    valid_res_o = !cls_q[CORDIC_STEPS].zero_vec;
    heading_o   = cls_q[CORDIC_STEPS].zero_vec ? '0 : head_full[HEADING_WIDTH-1:0];
  end

  assign out_push_o = en && vld_q[CORDIC_STEPS];

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved while stalled");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i) else $error("result transfer into full queue");
`endif

endmodule

FILE: hdl/cursor_heading_angle_core.sv
// ----------------------------------------------------------------------------
// cursor_heading_angle_core: cursor heading from a configurable origin
// Queue-style front end, two-entry operand queue, vectoring pipeline, result queue.
// ----------------------------------------------------------------------------
// Takes one cursor sample per clock while full is low and returns its heading
// in degrees with ANGLE_FRAC_BITS fractional bits (valid_res low and heading 0
// when the point coincides with the origin). The back end is a 25-stage
// vectoring pipeline, a pre-rotation stage followed by one micro-rotation per
// stage; throughput is one transfer per cycle while pop keeps up. Write the
// origin registers only while the core is empty.
module cursor_heading_angle_core
  import chd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [REG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [((COORD_WIDTH > OFFSET_WIDTH) ? COORD_WIDTH : OFFSET_WIDTH)-1:0]
                                        cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] cursor_x_i,
  input  logic signed [COORD_WIDTH-1:0] cursor_y_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [HEADING_WIDTH-1:0] heading_o,
  output logic                          valid_res_o
);

  localparam int DW    = COORD_WIDTH + 4;
  localparam int MID_W = 2 * DW + $bits(chd_class_t);
  localparam int OUT_W = HEADING_WIDTH + 1;

  logic signed [DW-1:0] f_dx, f_dy, b_dx, b_dy;
  chd_class_t           f_cls, b_cls;
  logic [MID_W-1:0]     mid_wdata, mid_rdata;
  logic                 mid_push, mid_pop, mid_full, mid_empty;
  logic [OUT_W-1:0]     out_wdata, out_rdata;
  logic                 out_push, out_full;
  logic [HEADING_WIDTH-1:0] b_heading;
  logic                 b_valid_res;

  chd_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cursor_x_i (cursor_x_i),
    .cursor_y_i (cursor_y_i),
    .dx_o       (f_dx),
    .dy_o       (f_dy),
    .class_o    (f_cls)
  );

  assign full      = mid_full;
  assign mid_push  = push && !mid_full;
  assign mid_wdata = {f_cls, f_dx, f_dy};

  chd_fifo #(
    .WIDTH(MID_W)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_wdata),
    .pop_i  (mid_pop),
    .data_o (mid_rdata),
    .full_o (mid_full),
    .empty_o(mid_empty)
  );

  assign {b_cls, b_dx, b_dy} = mid_rdata;

  chd_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!mid_empty),
    .dx_i       (b_dx),
    .dy_i       (b_dy),
    .class_i    (b_cls),
    .in_pop_o   (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .heading_o  (b_heading),
    .valid_res_o(b_valid_res)
  );

  assign out_wdata = {b_heading, b_valid_res};

  chd_fifo #(
    .WIDTH(OUT_W)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wdata),
    .pop_i  (pop && !empty),
    .data_o (out_rdata),
    .full_o (out_full),
    .empty_o(empty)
  );

  assign heading_o   = out_rdata[OUT_W-1:1];
  assign valid_res_o = out_rdata[0];

endmodule

FILE: dv/cursor_heading_angle_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_heading_angle_core_tb: self-checking bench of the cursor heading core
// Drives cursor samples through the push/full side under several origin
// settings and idling patterns. A behavioural vectoring predictor in the bench
// works out the heading of each accepted sample, and every transfer popped from
// the result side is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cursor_heading_angle_core_tb;
  import chd_pkg::*;

  localparam int COORD_W        = DEF_COORD_WIDTH;
  localparam int WDATA_W        = (COORD_W > OFFSET_WIDTH) ? COORD_W : OFFSET_WIDTH;
  localparam int ROT_STEPS      = 24;
  localparam int Z_FRAC         = 24;
  localparam int VEC_GUARD      = 24;
  localparam int HEAD_FRAC      = DEF_ANGLE_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;

  localparam logic [REG_IDX_WIDTH-1:0] REG_UNMAPPED = 2'd3;

  // atan(2^-i) in degrees, q24
  localparam longint ATAN_DEG_Q24 [ROT_STEPS] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115
  };

  typedef struct packed {
    logic signed [HEADING_WIDTH-1:0] heading;
    logic                            valid_res;
  } heading_res_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [REG_IDX_WIDTH-1:0]        cfg_idx_i;
  logic [WDATA_W-1:0]              cfg_wdata_i;
  logic                            push;
  logic                            full;
  logic signed [COORD_W-1:0]       cursor_x_i;
  logic signed [COORD_W-1:0]       cursor_y_i;
  logic                            empty;
  logic                            pop;
  logic signed [HEADING_WIDTH-1:0] heading_o;
  logic                            valid_res_o;

  logic signed [COORD_W-1:0]       origin_x;
  logic signed [COORD_W-1:0]       origin_y;
  logic signed [OFFSET_WIDTH-1:0]  origin_off;

  heading_res_t heading_exp_q [$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           rx_hold_cycles;
  int           mismatch_count;

  cursor_heading_angle_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .cursor_x_i  (cursor_x_i),
    .cursor_y_i  (cursor_y_i),
    .empty       (empty),
    .pop         (pop),
    .heading_o   (heading_o),
    .valid_res_o (valid_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic heading_res_t predict_heading(input logic signed [COORD_W-1:0] x,
                                                   input logic signed [COORD_W-1:0] y);
    heading_res_t res;
    longint       dx;
    longint       dy;
    longint       vx;
    longint       vy;
    longint       xs;
    longint       ys;
    longint       z;
    longint       swap;
    longint       ang;
    longint       head;
    dx = 4 * (longint'(x) - longint'(origin_x));
    dy = 4 * (longint'(y) - longint'(origin_y)) + 3 * longint'(origin_off);
    if (dx == 0 && dy == 0) begin
      res.heading   = '0;
      res.valid_res = 1'b0;
      return res;
    end
    vx = dy;
    vy = (dx < 0) ? -dx : dx;
    z  = 0;
    // quarter-turn pre-rotation into the right half plane
    if (vx < 0) begin
      swap = vx;
      vx   = vy;
      vy   = -swap;
      z    = longint'(90) << Z_FRAC;
    end
    vx = vx * (longint'(1) << VEC_GUARD);
    vy = vy * (longint'(1) << VEC_GUARD);
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys;
        vy = vy - xs;
        z  = z + ATAN_DEG_Q24[i];
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        z  = z - ATAN_DEG_Q24[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(180) << Z_FRAC)) z = longint'(180) << Z_FRAC;
    ang = (z + (longint'(1) << (Z_FRAC - HEAD_FRAC - 1))) >>> (Z_FRAC - HEAD_FRAC);
    // right side with dy of zero keeps the subtracting branch
    if (dx > 0 && dy != 0) head = (longint'(90) << HEAD_FRAC) + ang;
    else                   head = (longint'(90) << HEAD_FRAC) - ang;
    res.heading   = head[HEADING_WIDTH-1:0];
    res.valid_res = 1'b1;
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip_coord(input int v);
    if (v < -(1 << (COORD_W - 1))) v = -(1 << (COORD_W - 1));
    if (v > (1 << (COORD_W - 1)) - 1) v = (1 << (COORD_W - 1)) - 1;
    return COORD_W'(v);
  endfunction

  task automatic send_sample(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push       <= 1'b1;
    cursor_x_i <= x;
    cursor_y_i <= y;
    do @(posedge clk_i); while (full);
    heading_exp_q.push_back(predict_heading(x, y));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (heading_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_origin(input int cx, input int cy, input int off);
    logic [WDATA_W-1:0] off_word;
    off_word                   = WDATA_W'($urandom);
    off_word[OFFSET_WIDTH-1:0] = OFFSET_WIDTH'(off);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CENTER_X;
    cfg_wdata_i <= WDATA_W'(cx);
    @(posedge clk_i);
    cfg_idx_i   <= REG_CENTER_Y;
    cfg_wdata_i <= WDATA_W'(cy);
    @(posedge clk_i);
    cfg_idx_i   <= REG_VERT_OFFSET;
    cfg_wdata_i <= off_word;
    @(posedge clk_i);
    // unmapped index must leave the origin alone
    cfg_idx_i   <= REG_UNMAPPED;
    cfg_wdata_i <= WDATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    origin_x   = COORD_W'(cx);
    origin_y   = COORD_W'(cy);
    origin_off = OFFSET_WIDTH'(off);
  endtask

  task automatic test_reset_origin_special_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample(12'sd320, 12'sd205);
    send_sample(12'sd400, 12'sd205);
    send_sample(12'sd100, 12'sd205);
    send_sample(12'sd320, 12'sd600);
    send_sample(12'sd320, -12'sd300);
    send_sample(12'sd321, 12'sd204);
    send_sample(12'sd319, 12'sd204);
    send_sample(12'sd500, 12'sd400);
    send_sample(-12'sd2048, -12'sd2048);
    send_sample(12'sd2047, 12'sd2047);
    send_sample(-12'sd2048, 12'sd2047);
    send_sample(12'sd2047, -12'sd2048);
    drain_results();
  endtask

  task automatic test_extreme_origins();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_origin(-2048, -2048, -1024);
    send_sample(-12'sd2048, -12'sd1280);
    send_sample(12'sd2047, 12'sd2047);
    send_sample(-12'sd2048, 12'sd2047);
    send_sample(12'sd2047, -12'sd2048);
    drain_results();
    set_origin(2047, 2047, 1023);
    send_sample(-12'sd2048, -12'sd2048);
    send_sample(12'sd2047, 12'sd2047);
    send_sample(12'sd2047, -12'sd2048);
    send_sample(-12'sd2048, 12'sd2047);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_sets, input int n_items,
                                     input int idle_pct, input int stall_pct);
    int                        cx;
    int                        cy;
    int                        off;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_sets) begin
      if ($urandom_range(3) == 0) begin
        cx  = $urandom_range(1) ? 2047 : -2048;
        cy  = $urandom_range(1) ? 2047 : -2048;
        off = $urandom_range(1) ? 1023 : -1024;
      end else begin
        cx  = int'($urandom_range(4095)) - 2048;
        cy  = int'($urandom_range(4095)) - 2048;
        off = int'($urandom_range(2047)) - 1024;
      end
      // multiples of four let the point land on the origin
      if ($urandom_range(1)) off = off & ~3;
      set_origin(cx, cy, off);
      repeat (n_items) begin
        if ($urandom_range(9) < 7) begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end else begin
          x = clip_coord(cx + int'($urandom_range(6)) - 3);
          y = clip_coord(cy - (3 * off) / 4 + int'($urandom_range(6)) - 3);
        end
        send_sample(x, y);
      end
      drain_results();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (64) send_sample(COORD_W'($urandom), COORD_W'($urandom));
    drain_results();
    recv_stall_pct = 50;
    repeat (20) send_sample(COORD_W'($urandom), COORD_W'($urandom));
    drain_results();
  endtask

  initial begin : result_checker
    heading_res_t exp_res;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (heading_exp_q.size() == 0) begin
          $error("unexpected result transfer: heading %0d, valid_res %0b",
                 heading_o, valid_res_o);
          mismatch_count++;
        end else begin
          exp_res = heading_exp_q.pop_front();
          if (heading_o !== exp_res.heading) begin
            $error("heading: expected %0d, got %0d", exp_res.heading, heading_o);
            mismatch_count++;
          end
          if (valid_res_o !== exp_res.valid_res) begin
            $error("valid_res: expected %0b, got %0b", exp_res.valid_res, valid_res_o);
            mismatch_count++;
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || cfg_we_i || !rst_ni) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** cursor_heading_angle_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_CENTER_X;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    cursor_x_i  <= '0;
    cursor_y_i  <= '0;
    origin_x       = COORD_W'(CENTER_X_RESET);
    origin_y       = COORD_W'(CENTER_Y_RESET);
    origin_off     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_cycles = 0;
    mismatch_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_origin_special_cases();
    test_extreme_origins();
    test_random_traffic(4, 45, 0, 0);
    test_random_traffic(4, 45, 83, 0);
    test_random_traffic(4, 45, 0, 83);
    test_random_traffic(4, 45, 14, 14);
    test_output_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (heading_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", heading_exp_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** cursor_heading_angle_core: PASSED **");
    end else begin
      $display("** cursor_heading_angle_core: FAILED **");
    end
    $finish;
  end

endmodule
